FILE: design/imh_pkg.sv
// Package for the indexed min-heap: constants, command and status codes,
// word structs and the sequencer state type. Depends on nothing.
package imh_pkg;

   localparam int CAPACITY = 1024;
   localparam int HANDLE_W = 10;
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = SLOT_W + 1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_PRESENT = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [HANDLE_W-1:0]       handle;
      logic signed [KEY_W-1:0]   key;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic                      top_valid;
      logic [HANDLE_W-1:0]       top_handle;
      logic signed [KEY_W-1:0]   top_key;
      logic [SLOT_W-1:0]         item_count;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [HANDLE_W-1:0]       handle;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_DEL_RD, S_UP_RD, S_UP_CMP,
      S_DN_L, S_DN_R, S_DN_TWO, S_DN_MIN, S_WRITE, S_RESP
   } state_type;

endpackage

FILE: design/indexed_min_heap.sv
// Indexed binary min-heap with a handle-to-slot position table.
// Depends on imh_pkg.
//
// Usage: drive req_word and raise start; the word is taken at a clock edge
// where start is high and busy is low. The block then works on the command
// alone and answers with one rsp_word, shown for exactly one cycle with
// rsp_valid high. The receiver cannot hold the answer off and must take it
// in that cycle. Commands are insert, delete by handle and key update.
// Errors (heap full, handle absent, handle already present) change nothing.
// The answer carries the status, the top of the heap and the item count.
//
// Steps: an error, the unused command or a delete of the last slot goes
// from S_LOOK straight to S_RESP. A sift up passes S_UP_RD and S_UP_CMP
// for each level climbed, and a sift down S_DN_L, S_DN_R, S_DN_TWO and
// S_DN_MIN for each level descended (S_DN_TWO is skipped where only a left
// child exists), since one shared key comparator and a heap memory with
// one write port and one registered read port serve every step. Busy stays
// high through the answer; the next word is taken in the cycle after it.
//
// Reset: count returns to zero, and a clearing pass writes zero over all
// 1024 entries of the position table, one per cycle; busy is high for the
// whole pass. The heap slot memory is never cleared; only the contents of
// filled slots are ever used.
module indexed_min_heap (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  imh_pkg::req_type req_word,
   output logic            rsp_valid,
   output imh_pkg::rsp_type rsp_word
);
   import imh_pkg::*;

   // Heap slots 1..CAPACITY, and the slot held by each handle (zero: absent).
   entry_type          heap_mem [0:CAPACITY];
   logic [SLOT_W-1:0]  pos_mem  [0:(1<<HANDLE_W)-1];

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [CHILD_W-1:0]  chd_ff, chd_in;
   logic [HANDLE_W-1:0] clr_ff, clr_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [1:0]          status_ff, status_in;
   logic                moved_ff, moved_in;
   entry_type           item_ff, item_in;
   entry_type           lft_ff, lft_in;
   entry_type           top_ff;

   entry_type           heap_rd_ff;
   logic [SLOT_W-1:0]   pos_rd_ff;

   logic                heap_we;
   logic [SLOT_W-1:0]   heap_waddr, heap_raddr;
   entry_type           heap_wdata;
   logic                pos_we;
   logic [HANDLE_W-1:0] pos_waddr, pos_raddr;
   logic [SLOT_W-1:0]   pos_wdata;

   logic signed [KEY_W-1:0] cmp_a, cmp_b;
   logic                    cmp_lt;
   logic [CHILD_W-1:0]      left_idx;

   assign cmp_lt   = cmp_a < cmp_b;
   assign left_idx = {cur_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      heap_rd_ff <= heap_mem[heap_raddr];
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
      // The top of the heap is mirrored in a register on every slot 1 write.
      if (heap_we && heap_waddr == SLOT_W'(1)) begin
         top_ff <= heap_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
      cur_ff    <= cur_in;
      chd_ff    <= chd_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      moved_ff  <= moved_in;
      item_ff   <= item_in;
      lft_ff    <= lft_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      chd_in     = chd_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      status_in  = status_ff;
      moved_in   = moved_ff;
      item_in    = item_ff;
      lft_in     = lft_ff;
      heap_we    = 1'b0;
      heap_waddr = cur_ff;
      heap_wdata = item_ff;
      heap_raddr = cur_ff;
      pos_we     = 1'b0;
      pos_waddr  = item_ff.handle;
      pos_wdata  = cur_ff;
      pos_raddr  = req_word.handle;
      cmp_a      = item_ff.key;
      cmp_b      = heap_rd_ff.key;

      unique case (state_ff)
         S_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in         = req_word.cmd;
               item_in.key    = req_word.key;
               item_in.handle = req_word.handle;
               status_in      = ST_OK;
               moved_in       = 1'b0;
               state_in       = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (pos_rd_ff != '0) begin
                     status_in = ST_PRESENT;
                  end else if (count_ff == SLOT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     cur_in   = count_ff + 1'b1;
                     state_in = S_UP_RD;
                  end
               end
               CMD_DELETE: begin
                  if (pos_rd_ff == '0 || pos_rd_ff > count_ff) begin
                     status_in = ST_ABSENT;
                  end else begin
                     pos_we    = 1'b1;
                     pos_wdata = '0;
                     count_in  = count_ff - 1'b1;
                     if (pos_rd_ff != count_ff) begin
                        // Fetch the last item; it refills the vacated slot.
                        heap_raddr = count_ff;
                        cur_in     = pos_rd_ff;
                        state_in   = S_DEL_RD;
                     end
                  end
               end
               CMD_UPDATE: begin
                  if (pos_rd_ff == '0 || pos_rd_ff > count_ff) begin
                     status_in = ST_ABSENT;
                  end else begin
                     cur_in   = pos_rd_ff;
                     state_in = S_UP_RD;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_DEL_RD: begin
            item_in  = heap_rd_ff;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            heap_raddr = cur_ff >> 1;
            if (cur_ff == SLOT_W'(1)) begin
               state_in = moved_ff ? S_WRITE : S_DN_L;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // Parent is larger: it drops into the hole and the hole climbs.
            if (cmp_lt) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rd_ff;
               pos_we     = 1'b1;
               pos_waddr  = heap_rd_ff.handle;
               cur_in     = cur_ff >> 1;
               moved_in   = 1'b1;
               state_in   = S_UP_RD;
            end else begin
               state_in = moved_ff ? S_WRITE : S_DN_L;
            end
         end
         S_DN_L: begin
            heap_raddr = left_idx[SLOT_W-1:0];
            chd_in     = left_idx;
            if (left_idx > CHILD_W'(count_ff)) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            lft_in     = heap_rd_ff;
            heap_raddr = SLOT_W'(chd_ff + 1'b1);
            if (chd_ff == CHILD_W'(count_ff)) begin
               state_in = S_DN_MIN;
            end else begin
               state_in = S_DN_TWO;
            end
         end
         S_DN_TWO: begin
            // Pick the smaller child; on equal keys the right one wins.
            cmp_a = lft_ff.key;
            cmp_b = heap_rd_ff.key;
            if (!cmp_lt) begin
               lft_in = heap_rd_ff;
               chd_in = chd_ff + 1'b1;
            end
            state_in = S_DN_MIN;
         end
         S_DN_MIN: begin
            cmp_a = lft_ff.key;
            cmp_b = item_ff.key;
            if (cmp_lt) begin
               heap_we    = 1'b1;
               heap_wdata = lft_ff;
               pos_we     = 1'b1;
               pos_waddr  = lft_ff.handle;
               cur_in     = chd_ff[SLOT_W-1:0];
               state_in   = S_DN_L;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            heap_we  = 1'b1;
            pos_we   = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      rsp_word.status     = status_ff;
      rsp_word.top_valid  = count_ff != '0;
      rsp_word.top_handle = (count_ff != '0) ? top_ff.handle : '0;
      rsp_word.top_key    = (count_ff != '0) ? top_ff.key : '0;
      rsp_word.item_count = count_ff;
   end

endmodule
